### rtl/core/sset_pkg.sv
// Shared types, constants and elaboration helpers for the sorted set insert block.
package sset_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int HASH_BITS_DEF = 64;
  localparam int HASH_PORT_W   = 64;
  localparam int COUNT_OUT_W   = 11;
  localparam int TREE_FAN      = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TREE,
    ST_DECIDE
  } sset_state_e;

  typedef struct packed {
    logic cmp_en;
    logic shift_en;
  } cell_ctrl_t;

  // Registered OR-tree levels needed until at most TREE_FAN bits remain.
  function automatic int tree_levels(int w);
    int n;
    int c;
    n = 0;
    c = w;
    while (c > TREE_FAN) begin
      c = (c + TREE_FAN - 1) / TREE_FAN;
      n++;
    end
    return n;
  endfunction

  // Width of tree level lvl; level 0 is the leaf vector.
  function automatic int tree_width(int w, int lvl);
    int c;
    c = w;
    for (int i = 0; i < lvl; i++) begin
      c = (c + TREE_FAN - 1) / TREE_FAN;
    end
    return c;
  endfunction

  // Bit offset of tree level lvl (lvl >= 1) in the packed level register.
  function automatic int tree_offset(int w, int lvl);
    int s;
    s = 0;
    for (int k = 1; k < lvl; k++) begin
      s += tree_width(w, k);
    end
    return s;
  endfunction

endpackage

### rtl/core/sset_cell.sv
// One storage cell of the sorted row: holds an entry, compares it and shifts it up.
module sset_cell import sset_pkg::*; #(
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [HASH_BITS-1:0] key_i,
  input  logic [HASH_BITS-1:0] prev_entry_i,
  input  logic                 prev_occ_i,
  input  logic                 prev_take_i,
  output logic [HASH_BITS-1:0] entry_o,
  output logic                 occ_o,
  output logic                 take_o,
  output logic                 eq_o
);

  logic [HASH_BITS-1:0] entry_q, entry_d;
  logic                 occ_q, occ_d;
  logic                 take_q, eq_q;
  logic                 take_now, eq_now;

  // Take: this slot is at or past the insert point (empty or not below the key).
  assign take_now = !occ_q || (entry_q >= key_i);
  assign eq_now   = occ_q && (entry_q == key_i);

  always_comb begin
    entry_d = entry_q;
    occ_d   = occ_q;
    if (ctrl_i.shift_en && take_q) begin
      if (prev_take_i) begin
        entry_d = prev_entry_i;
        occ_d   = prev_occ_i;
      end else begin
        entry_d = key_i;
        occ_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.cmp_en) begin
      take_q <= take_now;
      eq_q   <= eq_now;
    end
  end

  assign entry_o = entry_q;
  assign occ_o   = occ_q;
  assign take_o  = take_q;
  assign eq_o    = eq_q;

endmodule

### rtl/core/sset_or_tree.sv
// Pipelined OR reduction of the per-cell match flags.
module sset_or_tree import sset_pkg::*; #(
  parameter int WIDTH = CAPACITY_DEF
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] eq_i,
  output logic             any_o
);

  localparam int LEVELS = tree_levels(WIDTH);

  if (LEVELS == 0) begin : g_flat
    assign any_o = |eq_i;
  end else begin : g_tree
    localparam int TOT_W   = tree_offset(WIDTH, LEVELS + 1);
    localparam int TOP_OFF = tree_offset(WIDTH, LEVELS);
    localparam int TOP_W   = tree_width(WIDTH, LEVELS);

    logic [TOT_W-1:0] tree_q, tree_d;

    always_comb begin
      tree_d = '0;
      for (int l = 1; l <= LEVELS; l++) begin
        for (int j = 0; j < tree_width(WIDTH, l); j++) begin
          for (int b = 0; b < TREE_FAN; b++) begin
            if (j * TREE_FAN + b < tree_width(WIDTH, l - 1)) begin
              if (l == 1) begin
                tree_d[tree_offset(WIDTH, l) + j] |= eq_i[j * TREE_FAN + b];
              end else begin
                tree_d[tree_offset(WIDTH, l) + j] |=
                  tree_q[tree_offset(WIDTH, l - 1) + j * TREE_FAN + b];
              end
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      tree_q <= tree_d;
    end

    assign any_o = |tree_q[TOP_OFF +: TOP_W];
  end

endmodule

### rtl/core/sorted_set_insert.sv
// Top level of the sorted set insert block: cell row, match tree and sequencer.
// Keeps up to CAPACITY distinct hashes in ascending order in a row of cells, one
// entry per cell, and answers each item with inserted / was_duplicate / was_full
// and the entry count after the item. Only the low HASH_BITS bits of hash_value_i
// take part. On acceptance every cell compares its entry with the hash at once and
// latches two flags: "at or past the insert point" and "equal". The equal flags
// are ORed through a pipelined 32-way tree (one register stage per level above 32
// flags; one stage at CAPACITY = 1024). In the decide cycle a new hash that fits
// makes every cell at or past the insert point take its lower neighbor's entry,
// while the first such cell takes the hash. A duplicate is reported even when the
// store is full. After acceptance an item passes the tree wait state (skipped when the
// tree has no stages) and then the decide state, which holds until the output register
// is free; the next item is accepted once the decide state has loaded its result, and a
// result may wait in the output register while the next item runs. There is no clearing
// pass: cell occupancy resets at once.
module sorted_set_insert import sset_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [HASH_PORT_W-1:0] hash_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   inserted_o,
  output logic                   was_duplicate_o,
  output logic                   was_full_o,
  output logic [COUNT_OUT_W-1:0] entry_count_o
);

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int LEVELS  = tree_levels(CAPACITY);
  localparam int WAIT_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  sset_state_e state_q, state_d;
  logic [WAIT_W-1:0]    wait_q, wait_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [HASH_BITS-1:0] key_q;
  logic [HASH_BITS-1:0] key_in, cell_key;

  logic                   out_valid_q, out_valid_d;
  logic                   ins_q, dup_q, full_q;
  logic                   ins_d, dup_d, full_d;
  logic [COUNT_OUT_W-1:0] out_count_q, out_count_d;

  logic       accept, out_free, any_eq, is_full, commit, load_out;
  cell_ctrl_t ctrl;

  // Chain wires: element i feeds cell i, cell i drives element i + 1.
  logic [HASH_BITS-1:0] chain_entry [CAPACITY+1];
  logic                 chain_occ   [CAPACITY+1];
  logic                 chain_take  [CAPACITY+1];
  logic [CAPACITY-1:0]  eq_vec;

  assign key_in   = hash_value_i[HASH_BITS-1:0];
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign is_full  = (count_q == CNT_W'(CAPACITY));

  // Compare against the incoming hash at acceptance, shift in the held one later.
  assign cell_key = (state_q == ST_IDLE) ? key_in : key_q;

  assign chain_entry[0] = key_q;
  assign chain_occ[0]   = 1'b0;
  assign chain_take[0]  = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sset_cell #(
      .HASH_BITS(HASH_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .key_i       (cell_key),
      .prev_entry_i(chain_entry[i]),
      .prev_occ_i  (chain_occ[i]),
      .prev_take_i (chain_take[i]),
      .entry_o     (chain_entry[i+1]),
      .occ_o       (chain_occ[i+1]),
      .take_o      (chain_take[i+1]),
      .eq_o        (eq_vec[i])
    );
  end

  sset_or_tree #(
    .WIDTH(CAPACITY)
  ) u_or_tree (
    .clk_i(clk_i),
    .eq_i (eq_vec),
    .any_o(any_eq)
  );

  // Sequencer: accept, wait out the match tree, then decide and post the result.
  always_comb begin
    state_d     = state_q;
    wait_d      = wait_q;
    count_d     = count_q;
    commit      = 1'b0;
    load_out    = 1'b0;
    ins_d       = ins_q;
    dup_d       = dup_q;
    full_d      = full_q;
    out_count_d = out_count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          wait_d  = '0;
          state_d = (LEVELS == 0) ? ST_DECIDE : ST_TREE;
        end
      end
      ST_TREE: begin
        if (wait_q == WAIT_W'(LEVELS - 1)) begin
          state_d = ST_DECIDE;
        end else begin
          wait_d = wait_q + WAIT_W'(1);
        end
      end
      ST_DECIDE: begin
        // Hold until the output register can take the result.
        if (out_free) begin
          load_out = 1'b1;
          commit   = !any_eq && !is_full;
          dup_d    = any_eq;
          full_d   = !any_eq && is_full;
          ins_d    = commit;
          if (commit) begin
            count_d = count_q + CNT_W'(1);
          end
          out_count_d = COUNT_OUT_W'(count_d);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ctrl.cmp_en   = accept;
  assign ctrl.shift_en = commit;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wait_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= key_in;
    end
    ins_q       <= ins_d;
    dup_q       <= dup_d;
    full_q      <= full_d;
    out_count_q <= out_count_d;
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign inserted_o      = ins_q;
  assign was_duplicate_o = dup_q;
  assign was_full_o      = full_q;
  assign entry_count_o   = out_count_q;

endmodule

### dv/sset_checker.sv
// Checker for the sorted set insert block: tracks the set and compares every result.
`timescale 1ns / 1ps
module sset_checker import sset_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [HASH_PORT_W-1:0] hash_value_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic                   inserted_i,
  input  logic                   was_duplicate_i,
  input  logic                   was_full_i,
  input  logic [COUNT_OUT_W-1:0] entry_count_i,
  output int                     pending_o,
  output int                     errors_o,
  output int                     inserted_cnt_o,
  output int                     dup_cnt_o,
  output int                     full_cnt_o
);

  typedef bit [HASH_BITS-1:0] key_t;

  typedef struct {
    bit                   inserted;
    bit                   duplicate;
    bit                   full;
    bit [COUNT_OUT_W-1:0] count;
  } set_result_t;

  key_t        stored_hashes[$];   // ascending, mirrors the cell row
  set_result_t awaited_results[$];
  set_result_t head_result;
  set_result_t new_result;
  int          errors       = 0;
  int          inserted_cnt = 0;
  int          dup_cnt      = 0;
  int          full_cnt     = 0;

  // Find the first entry >= key, then reject as duplicate, reject as full or insert.
  function automatic set_result_t apply_insert(key_t key);
    set_result_t r;
    int          lo;
    int          hi;
    int          mid;
    r.inserted  = 1'b0;
    r.duplicate = 1'b0;
    r.full      = 1'b0;
    lo = 0;
    hi = stored_hashes.size();
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (stored_hashes[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    if (lo < stored_hashes.size() && stored_hashes[lo] == key) begin
      r.duplicate = 1'b1;
    end else if (stored_hashes.size() >= CAPACITY) begin
      r.full = 1'b1;
    end else begin
      stored_hashes.insert(lo, key);
      r.inserted = 1'b1;
    end
    r.count = COUNT_OUT_W'(stored_hashes.size());
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("sset_checker: %s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Retire the result first, so an item accepted at the same edge never pairs with it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("sset_checker: result with no item outstanding");
          errors++;
        end else begin
          head_result = awaited_results.pop_front();
          check_field("inserted", 64'(head_result.inserted), 64'(inserted_i));
          check_field("was_duplicate", 64'(head_result.duplicate), 64'(was_duplicate_i));
          check_field("was_full", 64'(head_result.full), 64'(was_full_i));
          check_field("entry_count", 64'(head_result.count), 64'(entry_count_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        new_result = apply_insert(hash_value_i[HASH_BITS-1:0]);
        inserted_cnt += int'(new_result.inserted);
        dup_cnt      += int'(new_result.duplicate);
        full_cnt     += int'(new_result.full);
        awaited_results.push_back(new_result);
      end
    end
    pending_o      <= awaited_results.size();
    errors_o       <= errors;
    inserted_cnt_o <= inserted_cnt;
    dup_cnt_o      <= dup_cnt;
    full_cnt_o     <= full_cnt;
  end

endmodule

### dv/tb_top.sv
// Testbench top for the sorted set insert block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import sset_pkg::*;

  localparam int PHASE_ITEMS  = 510;   // random items per pacing phase
  localparam int HOLD_ITEMS   = 30;    // items offered while the output is held off
  localparam int LONG_HOLD    = 400;   // cycles the receiver refuses results
  localparam int DRAIN_CYCLES = 20;    // idle clocks after the drain, for a stray result

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   in_valid_i   = 1'b0;
  logic [HASH_PORT_W-1:0] hash_value_i = '0;
  logic                   out_ready_i  = 1'b0;
  logic                   in_ready_o;
  logic                   out_valid_o;
  logic                   inserted_o;
  logic                   was_duplicate_o;
  logic                   was_full_o;
  logic [COUNT_OUT_W-1:0] entry_count_o;

  // Pacing knobs, in percent of cycles spent idle.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // The stimulus bumps hold_requests; the receiver process serves each one once.
  int hold_requests = 0;
  int holds_done    = 0;

  int pending;
  int errors;
  int inserted_cnt;
  int dup_cnt;
  int full_cnt;
  int items_sent = 0;

  logic [HASH_PORT_W-1:0] sent_hashes[$];
  logic [HASH_PORT_W-1:0] directed_hashes[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sorted_set_insert i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .hash_value_i   (hash_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .inserted_o     (inserted_o),
    .was_duplicate_o(was_duplicate_o),
    .was_full_o     (was_full_o),
    .entry_count_o  (entry_count_o)
  );

  sset_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .hash_value_i   (hash_value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .inserted_i     (inserted_o),
    .was_duplicate_i(was_duplicate_o),
    .was_full_i     (was_full_o),
    .entry_count_i  (entry_count_o),
    .pending_o      (pending),
    .errors_o       (errors),
    .inserted_cnt_o (inserted_cnt),
    .dup_cnt_o      (dup_cnt),
    .full_cnt_o     (full_cnt)
  );

  // Offer one item: idle a random number of cycles, then hold valid and the hash
  // steady until the block takes the item. Return at the accepting edge with
  // valid still high, so a following item goes out back to back.
  task automatic send_hash(input logic [HASH_PORT_W-1:0] h);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    hash_value_i <= h;
    sent_hashes.push_back(h);
    items_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Mix fresh hashes (to fill the store), extremes, neighbors of stored
  // values (to land right beside an entry) and repeats (duplicates).
  function automatic logic [HASH_PORT_W-1:0] pick_hash();
    int                     r;
    logic [HASH_PORT_W-1:0] base;
    r = $urandom_range(0, 99);
    if (r < 62 || sent_hashes.size() == 0) return {$urandom(), $urandom()};
    base = sent_hashes[$urandom_range(0, sent_hashes.size() - 1)];
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        2:       return HASH_PORT_W'($urandom_range(0, 255));
        default: return HASH_PORT_W'(1) << $urandom_range(0, HASH_PORT_W - 1);
      endcase
    end
    if (r < 80) return $urandom_range(0, 1) ? base + 1 : base - 1;
    return base;
  endfunction

  // Sit until the checker has seen every outstanding result.
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Receiver: random ready, or a long hold-off when the stimulus asks for one.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_requests != holds_done) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    // Empty-set inserts and duplicates at both ends, the MSB, neighbors of
    // stored values, an ascending and a descending run, alternating bits.
    directed_hashes = '{
      64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
      64'hFFFF_FFFF_FFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFF,
      64'h0000_0000_0000_0001, 64'h0000_0000_0000_0010,
      64'h0000_0000_0000_0020, 64'h0000_0000_0000_0030,
      64'h0000_0000_0000_0300, 64'h0000_0000_0000_0200,
      64'h0000_0000_0000_0100, 64'h0000_0000_0000_0020,
      64'h0000_0000_0000_001F, 64'h0000_0000_0000_0021,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Slow sender, mostly stalled receiver.
    send_idle_pct = 15;
    recv_idle_pct = 84;
    foreach (directed_hashes[i]) send_hash(directed_hashes[i]);
    repeat (PHASE_ITEMS) send_hash(pick_hash());

    // Mostly idle sender, eager receiver.
    send_idle_pct = 84;
    recv_idle_pct = 15;
    repeat (PHASE_ITEMS) send_hash(pick_hash());

    // Full rate. Hold the output off first so the block backs up into its
    // input, then pause the sender until every result is home.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (HOLD_ITEMS) send_hash(pick_hash());
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (PHASE_ITEMS - HOLD_ITEMS) send_hash(pick_hash());

    // Drain, then give the block time to show any stray result.
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb_top: %0d items sent: %0d stored, %0d duplicates, %0d refused on a full set",
             items_sent, inserted_cnt, dup_cnt, full_cnt);
    $display("tb_top: both sides paced at random, plus a %0d-cycle output hold and a drain",
             LONG_HOLD);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### files.f
rtl/core/sset_pkg.sv
rtl/core/sset_cell.sv
rtl/core/sset_or_tree.sv
rtl/core/sorted_set_insert.sv
dv/sset_checker.sv
dv/tb_top.sv
